### src/lbaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lbaf_pkg;

  typedef enum logic [1:0] {
    REQ_BLOB = 2'd0,
    REQ_FADE = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BLOB_RD,
    ST_BLOB_DIV,
    ST_BLOB_SQ,
    ST_BLOB_R,
    ST_BLOB_G,
    ST_BLOB_B,
    ST_FADE_RD,
    ST_FADE_R,
    ST_FADE_G,
    ST_FADE_B,
    ST_READ,
    ST_READ_CAP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  localparam logic [7:0] FADE_RESET = 8'd235;
  localparam logic [7:0] CHAN_MAX   = 8'd255;
  localparam logic       REG_FADE   = 1'b0;

  // weight divider geometry: 255*(radius-d) over radius, quotient below 256
  localparam int QUOT_W = 8;
  localparam int DEN_W  = 8;
  localparam int NUM_W  = 16;

  function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
    logic [16:0] p;
    p = 17'(a) * (17'(b) + 17'd1);
    return p[15:8];
  endfunction

  function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? CHAN_MAX : s[7:0];
  endfunction

endpackage
`default_nettype wire

### src/lbaf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module lbaf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1792,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### src/lbaf_div.sv
`timescale 1ns / 1ps
`default_nettype none
module lbaf_div
  import lbaf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  output logic                   done_o,
  output logic      [QUOT_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(QUOT_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [NUM_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [QUOT_W-1:0] quot_q;
  logic [NUM_W:0]    trial;
  logic              borrow;

  // restoring division, one quotient bit per cycle, MSB first
  always_comb begin
    trial  = {1'b0, rem_q} - {1'b0, NUM_W'(den_q) << cnt_q};
    borrow = trial[NUM_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUOT_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      if (!borrow) begin
        rem_q <= trial[NUM_W-1:0];
      end
      quot_q <= {quot_q[QUOT_W-2:0], ~borrow};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

### src/led_blob_accumulate_fade.sv
`timescale 1ns / 1ps
`default_nettype none
// Read request: returns the stored pixel. Blob: each touched LED passes
// through the weight divider and then the single scale8 multiplier that
// serves the weight square and the three channels in turn.
// Fade: NUM_STRIPS*LEDS_PER_STRIP pixels, one at a time, one RAM port each way.
// One request at a time; the result register lets the next request enter.
// Reset: a clearing pass over all NUM_STRIPS*LEDS_PER_STRIP addresses zeroes the store.
module led_blob_accumulate_fade
  import lbaf_pkg::*;
#(
  parameter int NUM_STRIPS     = 7,
  parameter int LEDS_PER_STRIP = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // strip_select[2:0], blob_center[10:3], blob_radius[18:11], strip_length[27:19],
  // red_in[35:28], green_in[43:36], blue_in[51:44], read_index[59:52], zero[63:60]
  input  wire logic [63:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic [23:0]      m_axis_tdata,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int DEPTH = NUM_STRIPS * LEDS_PER_STRIP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = AW + 4;
  localparam int CW    = (($clog2(LEDS_PER_STRIP + 1) > 9) ? $clog2(LEDS_PER_STRIP + 1) : 9) + 1;

  state_e         state_q, state_d;
  logic [7:0]     fade_q;
  logic [7:0]     center_q, center_d;
  logic [7:0]     radius_q, radius_d;
  logic [7:0]     red_q, red_d;
  logic [7:0]     green_q, green_d;
  logic [7:0]     blue_q, blue_d;
  logic [AW-1:0]  addr_q, addr_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  end_q, end_d;
  logic [7:0]     w_q, w_d;
  logic [7:0]     acc_r_q, acc_r_d;
  logic [7:0]     acc_g_q, acc_g_d;
  pixel_t         res_q, res_d;
  logic           out_valid_q, out_valid_d;
  pixel_t         out_data_q, out_data_d;

  // request fields
  req_e           in_req;
  logic [2:0]     in_strip;
  logic [7:0]     in_center, in_radius, in_red, in_green, in_blue, in_index;
  logic [8:0]     in_len;

  logic           strip_ok, read_ok, blob_go;
  logic [CW-1:0]  lim, end_full, end_clip, start_c;
  logic [7:0]     start8;
  logic [PW-1:0]  base;

  // shared datapath
  logic [7:0]     mul_a, mul_b, prod;
  logic [CW-1:0]  dist_w;
  logic [7:0]     span;
  logic [15:0]    div_num;
  logic           div_start, div_done;
  logic [7:0]     div_quot;
  logic           ram_we;
  pixel_t         ram_wdata, ram_rdata;
  logic           last_pix;
  logic           cfg_we;

  assign in_req    = req_e'(s_axis_tuser);
  assign in_strip  = s_axis_tdata[2:0];
  assign in_center = s_axis_tdata[10:3];
  assign in_radius = s_axis_tdata[18:11];
  assign in_len    = s_axis_tdata[27:19];
  assign in_red    = s_axis_tdata[35:28];
  assign in_green  = s_axis_tdata[43:36];
  assign in_blue   = s_axis_tdata[51:44];
  assign in_index  = s_axis_tdata[59:52];

  // clip the blob span to the strip and to the store row
  always_comb begin
    strip_ok = CW'(in_strip) < CW'(NUM_STRIPS);
    read_ok  = strip_ok && (CW'(in_index) < CW'(LEDS_PER_STRIP));
    lim      = (CW'(in_len) > CW'(LEDS_PER_STRIP)) ? CW'(LEDS_PER_STRIP) : CW'(in_len);
    start8   = (in_center >= in_radius) ? in_center - in_radius : 8'd0;
    start_c  = CW'(start8);
    end_full = CW'(in_center) + CW'(in_radius);
    end_clip = (end_full > lim - 1'b1) ? lim - 1'b1 : end_full;
    blob_go  = strip_ok && (lim != '0) && (start_c <= end_clip);
    base     = PW'(in_strip) * PW'(LEDS_PER_STRIP);
  end

  // weight numerator 255*(radius-d)
  always_comb begin
    dist_w  = (idx_q >= CW'(center_q)) ? idx_q - CW'(center_q) : CW'(center_q) - idx_q;
    span    = radius_q - dist_w[7:0];
    div_num = {span, 8'd0} - {8'd0, span};
  end

  assign last_pix = (addr_q == AW'(DEPTH - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:    if (last_pix) state_d = ST_IDLE;
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (in_req)
            REQ_BLOB: state_d = blob_go ? ST_BLOB_RD : ST_DONE;
            REQ_FADE: state_d = ST_FADE_RD;
            REQ_READ: state_d = read_ok ? ST_READ : ST_DONE;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_BLOB_RD:  state_d = ST_BLOB_DIV;
      ST_BLOB_DIV: if (div_done) state_d = ST_BLOB_SQ;
      ST_BLOB_SQ:  state_d = ST_BLOB_R;
      ST_BLOB_R:   state_d = ST_BLOB_G;
      ST_BLOB_G:   state_d = ST_BLOB_B;
      ST_BLOB_B:   state_d = (idx_q == end_q) ? ST_DONE : ST_BLOB_RD;
      ST_FADE_RD:  state_d = ST_FADE_R;
      ST_FADE_R:   state_d = ST_FADE_G;
      ST_FADE_G:   state_d = ST_FADE_B;
      ST_FADE_B:   state_d = last_pix ? ST_DONE : ST_FADE_RD;
      ST_READ:     state_d = ST_READ_CAP;
      ST_READ_CAP: state_d = ST_DONE;
      ST_DONE:     if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // state outputs: handshake, multiplier operands, divider start, RAM write
  always_comb begin
    s_axis_tready = 1'b0;
    mul_a         = 8'd0;
    mul_b         = 8'd0;
    div_start     = 1'b0;
    ram_we        = 1'b0;
    ram_wdata     = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_BLOB_RD: begin
        div_start = 1'b1;
      end
      ST_BLOB_SQ: begin
        mul_a = div_quot;
        mul_b = div_quot;
      end
      ST_BLOB_R: begin
        mul_a = red_q;
        mul_b = w_q;
      end
      ST_BLOB_G: begin
        mul_a = green_q;
        mul_b = w_q;
      end
      ST_BLOB_B: begin
        mul_a     = blue_q;
        mul_b     = w_q;
        ram_we    = 1'b1;
        ram_wdata = '{r: acc_r_q, g: acc_g_q, b: sat_add8(ram_rdata.b, prod)};
      end
      ST_FADE_R: begin
        mul_a = ram_rdata.r;
        mul_b = fade_q;
      end
      ST_FADE_G: begin
        mul_a = ram_rdata.g;
        mul_b = fade_q;
      end
      ST_FADE_B: begin
        mul_a     = ram_rdata.b;
        mul_b     = fade_q;
        ram_we    = 1'b1;
        ram_wdata = '{r: acc_r_q, g: acc_g_q, b: prod};
      end
      default: ;
    endcase
  end

  assign prod = scale8(mul_a, mul_b);

  // datapath registers
  always_comb begin
    center_d    = center_q;
    radius_d    = radius_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    addr_d      = addr_q;
    idx_d       = idx_q;
    end_d       = end_q;
    w_d         = w_q;
    acc_r_d     = acc_r_q;
    acc_g_d     = acc_g_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        addr_d = last_pix ? '0 : addr_q + 1'b1;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          center_d = in_center;
          radius_d = in_radius;
          red_d    = in_red;
          green_d  = in_green;
          blue_d   = in_blue;
          idx_d    = start_c;
          end_d    = end_clip;
          res_d    = '0;
          case (in_req)
            REQ_BLOB: addr_d = AW'(base + PW'(start8));
            REQ_READ: addr_d = AW'(base + PW'(in_index));
            default:  addr_d = '0;
          endcase
        end
      end
      ST_BLOB_SQ: w_d = prod;
      ST_BLOB_R:  acc_r_d = sat_add8(ram_rdata.r, prod);
      ST_BLOB_G:  acc_g_d = sat_add8(ram_rdata.g, prod);
      ST_BLOB_B: begin
        idx_d  = idx_q + 1'b1;
        addr_d = addr_q + 1'b1;
      end
      ST_FADE_R:  acc_r_d = prod;
      ST_FADE_G:  acc_g_d = prod;
      ST_FADE_B:  addr_d = addr_q + 1'b1;
      ST_READ_CAP: res_d = ram_rdata;
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      idx_q       <= '0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    center_q   <= center_d;
    radius_q   <= radius_d;
    red_q      <= red_d;
    green_q    <= green_d;
    blue_q     <= blue_d;
    w_q        <= w_d;
    acc_r_q    <= acc_r_d;
    acc_g_q    <= acc_g_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  // a zero radius gives a zero numerator over a zero divisor, which the
  // restoring divider returns as all ones: the full weight of 255
  lbaf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (radius_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  lbaf_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_FADE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_q <= FADE_RESET;
    end else if (cfg_we) begin
      fade_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_FADE) ? {24'd0, fade_q} : 32'd0;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_data_q.b, out_data_q.g, out_data_q.r};

endmodule
`default_nettype wire
